// ===== sv/canonical_utf8_text_validator_core_assert.svh =====
// Assertion macros for the checker of the UTF-8 validator.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef CANONICAL_UTF8_TEXT_VALIDATOR_CORE_ASSERT_SVH
`define CANONICAL_UTF8_TEXT_VALIDATOR_CORE_ASSERT_SVH

// Check a property on every clock edge while reset is released.
`define CUTV_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define CUTV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/cutv_pkg.sv =====
// Shared types, constants and helpers of the canonical UTF-8 validator.
// No dependencies; imported by the front, queue, back and top modules.
package cutv_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned VQ_DEPTH    = 2;
    localparam int unsigned VPTR_W      = $clog2(VQ_DEPTH);
    localparam int unsigned VCNT_W      = $clog2(VQ_DEPTH + 1);

    localparam int unsigned CP_W        = 21;

    localparam logic [7:0] ASCII_MAX    = 8'h7F;
    localparam logic [7:0] CONT_MIN     = 8'h80;
    localparam logic [7:0] CONT_MAX     = 8'hBF;
    localparam logic [7:0] LEAD2_MIN    = 8'hC2;
    localparam logic [7:0] LEAD2_MAX    = 8'hDF;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD3_MAX    = 8'hEF;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD4_MAX    = 8'hF4;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] MARK_B0      = 8'hEF;
    localparam logic [7:0] MARK_B1      = 8'hBB;
    localparam logic [7:0] MARK_B2      = 8'hBF;

    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;

    localparam logic [1:0] MCLS_TWO   = 2'd0;
    localparam logic [1:0] MCLS_THREE = 2'd1;
    localparam logic [1:0] MCLS_FOUR  = 2'd2;

    typedef enum logic [2:0] {
        K_ASCII,
        K_CONT,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_BAD
    } t_kind;

    // One classified item as it travels from front to back.
    typedef struct packed {
        t_kind      kind;
        logic [5:0] bits;
        logic [2:0] mark_hit;
        logic       is_cr;
        logic       present;
        logic       last;
    } t_item;

    function automatic logic [CP_W-1:0] class_min(input logic [1:0] cls);
        logic [CP_W-1:0] v;
        case (cls)
            MCLS_TWO:   v = MIN_TWO;
            MCLS_THREE: v = MIN_THREE;
            default:    v = MIN_FOUR;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/cutv_front.sv =====
// Front end: accepts input items and classifies each byte.
// Depends on cutv_pkg.
module cutv_front (
    input  logic           i_push,
    input  logic [7:0]     i_data_byte,
    input  logic           i_byte_present,
    input  logic           i_end_of_text,
    input  logic           i_q_full,
    output logic           o_wr,
    output cutv_pkg::t_item o_item
);
    import cutv_pkg::*;

    t_kind w_kind;

    always_comb begin
        case (i_data_byte) inside
            [8'h00:ASCII_MAX]:     w_kind = K_ASCII;
            [CONT_MIN:CONT_MAX]:   w_kind = K_CONT;
            [LEAD2_MIN:LEAD2_MAX]: w_kind = K_LEAD2;
            [LEAD3_MIN:LEAD3_MAX]: w_kind = K_LEAD3;
            [LEAD4_MIN:LEAD4_MAX]: w_kind = K_LEAD4;
            default:               w_kind = K_BAD;
        endcase
    end

    always_comb begin
        o_item.kind        = w_kind;
        o_item.bits        = i_data_byte[5:0];
        o_item.mark_hit[0] = (i_data_byte == MARK_B0);
        o_item.mark_hit[1] = (i_data_byte == MARK_B1);
        o_item.mark_hit[2] = (i_data_byte == MARK_B2);
        o_item.is_cr       = (i_data_byte == CHAR_CR);
        o_item.present     = i_byte_present;
        o_item.last        = i_end_of_text;
    end

    // Drop items that carry neither a byte nor an end marker.
    assign o_wr = i_push && !i_q_full && (i_byte_present || i_end_of_text);

endmodule

// ===== sv/cutv_queue.sv =====
// Short item queue between the front and back ends.
// Depends on cutv_pkg.
module cutv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  cutv_pkg::t_item i_data,
    input  logic            i_rd,
    output cutv_pkg::t_item o_data,
    output logic            o_empty,
    output logic            o_full
);
    import cutv_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_cnt,  n_cnt;

    always_comb begin
        n_wptr = i_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr = i_rd ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== sv/cutv_back.sv =====
// Back end: runs the UTF-8 and canonical checks and queues verdicts.
// Depends on cutv_pkg.
module cutv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_canon,
    input  logic            i_valid,
    input  cutv_pkg::t_item i_item,
    output logic            o_take,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_text_valid
);
    import cutv_pkg::*;

    logic [1:0]      r_pend,  n_pend;
    logic [CP_W-1:0] r_acc,   n_acc;
    logic [1:0]      r_mcls,  n_mcls;
    logic            r_fail,  n_fail;
    logic [1:0]      r_seen,  n_seen;
    logic            r_match, n_match;

    logic            r_vmem [VQ_DEPTH];
    logic [VPTR_W-1:0] r_vwptr, r_vrptr;
    logic [VCNT_W-1:0] r_vcnt,  n_vcnt;

    logic            w_hit;
    logic            w_vpush;
    logic            w_vpop;
    logic            w_verdict;
    logic [CP_W-1:0] w_cp;

    // Stall only an end item, and only while the verdict queue is full.
    assign o_take  = i_valid && (!i_item.last || (r_vcnt != VCNT_W'(VQ_DEPTH)));
    assign w_vpush = o_take && i_item.last;
    assign w_vpop  = i_pop && (r_vcnt != '0);

    always_comb begin
        case (r_seen)
            2'd0:    w_hit = i_item.mark_hit[0];
            2'd1:    w_hit = i_item.mark_hit[1];
            2'd2:    w_hit = i_item.mark_hit[2];
            default: w_hit = 1'b0;
        endcase
    end

    assign w_cp = {r_acc[CP_W-7:0], i_item.bits};

    always_comb begin
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_mcls  = r_mcls;
        n_fail  = r_fail;
        n_seen  = r_seen;
        n_match = r_match;
        w_verdict = 1'b0;

        if (o_take && i_item.present) begin
            if (r_seen != 2'd3) begin
                n_match = r_match && w_hit;
                n_seen  = r_seen + 2'd1;
                if ((r_seen == 2'd2) && n_match && i_canon) begin
                    n_fail = 1'b1;
                end
            end
            if (i_item.is_cr && i_canon) begin
                n_fail = 1'b1;
            end

            if (r_pend == 2'd0) begin
                case (i_item.kind)
                    K_ASCII: begin
                    end
                    K_LEAD2: begin
                        n_pend = 2'd1;
                        n_acc  = CP_W'(i_item.bits[4:0]);
                        n_mcls = MCLS_TWO;
                    end
                    K_LEAD3: begin
                        n_pend = 2'd2;
                        n_acc  = CP_W'(i_item.bits[3:0]);
                        n_mcls = MCLS_THREE;
                    end
                    K_LEAD4: begin
                        n_pend = 2'd3;
                        n_acc  = CP_W'(i_item.bits[2:0]);
                        n_mcls = MCLS_FOUR;
                    end
                    default: n_fail = 1'b1;
                endcase
            end else if (i_item.kind != K_CONT) begin
                // Broken sequence: drop it and keep scanning.
                n_fail = 1'b1;
                n_pend = 2'd0;
                n_acc  = '0;
            end else begin
                n_pend = r_pend - 2'd1;
                n_acc  = w_cp;
                if (r_pend == 2'd1) begin
                    if ((w_cp < class_min(r_mcls)) || (w_cp > CP_MAX) ||
                        ((w_cp >= SURR_LO) && (w_cp <= SURR_HI))) begin
                        n_fail = 1'b1;
                    end
                    n_acc = '0;
                end
            end
        end

        if (w_vpush) begin
            w_verdict = !n_fail && (n_pend == 2'd0);
            n_pend  = 2'd0;
            n_acc   = '0;
            n_mcls  = MCLS_TWO;
            n_fail  = 1'b0;
            n_seen  = 2'd0;
            n_match = 1'b1;
        end
    end

    always_comb begin
        n_vcnt = r_vcnt;
        if (w_vpush && !w_vpop) begin
            n_vcnt = r_vcnt + 1'b1;
        end else if (!w_vpush && w_vpop) begin
            n_vcnt = r_vcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 2'd0;
            r_acc   <= '0;
            r_mcls  <= MCLS_TWO;
            r_fail  <= 1'b0;
            r_seen  <= 2'd0;
            r_match <= 1'b1;
            r_vwptr <= '0;
            r_vrptr <= '0;
            r_vcnt  <= '0;
        end else begin
            r_pend  <= n_pend;
            r_acc   <= n_acc;
            r_mcls  <= n_mcls;
            r_fail  <= n_fail;
            r_seen  <= n_seen;
            r_match <= n_match;
            r_vcnt  <= n_vcnt;
            if (w_vpush) begin
                r_vwptr <= r_vwptr + 1'b1;
            end
            if (w_vpop) begin
                r_vrptr <= r_vrptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vpush) begin
            r_vmem[r_vwptr] <= w_verdict;
        end
    end

    assign o_empty      = (r_vcnt == '0);
    assign o_text_valid = r_vmem[r_vrptr];

endmodule

// ===== sv/canonical_utf8_text_validator_core.sv =====
// Strict UTF-8 document validator with optional canonical-form checks.
// Depends on cutv_pkg, cutv_front, cutv_queue and cutv_back.
//
// Input channel: drive data_byte, byte_present and end_of_text with push;
// the item is taken on a clock edge with push high and full low. Items with
// neither a byte nor an end marker are dropped.
// Result channel: one text_valid verdict per end_of_text item, shown while
// empty is low and taken on an edge with pop high.
// Throughput: one item per clock while the result queue has room. With both
// queues empty, an accepted end item passes the item queue, is judged by the
// back end and its verdict is written into the result queue, ready to pop.
// The front end classifies each byte into a 4-entry queue; the back end
// updates the running sequence state one byte per clock, unless an end item
// is held by a full result queue, and writes verdicts into a 2-entry result queue.
// Stall: if pop stays low, the result queue fills, the back end holds the
// next end item, the item queue fills and full rises.
// Reset (synchronous, active low) empties both queues, clears the document
// state and sets r_canon to 1. Write i_cfg_wdata with i_cfg_we
// only while no document is in flight.
module canonical_utf8_text_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic       o_text_valid
);
    import cutv_pkg::*;

    logic  r_canon, n_canon;
    logic  w_wr;
    t_item w_in_item;
    t_item w_head;
    logic  w_q_empty;
    logic  w_take;

    assign n_canon = i_cfg_we ? i_cfg_wdata : r_canon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon <= 1'b1;
        end else begin
            r_canon <= n_canon;
        end
    end

    cutv_front u_front (
        .i_push         (push),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .i_q_full       (full),
        .o_wr           (w_wr),
        .o_item         (w_in_item)
    );

    cutv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (w_in_item),
        .i_rd    (w_take),
        .o_data  (w_head),
        .o_empty (w_q_empty),
        .o_full  (full)
    );

    cutv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_canon      (r_canon),
        .i_valid      (!w_q_empty),
        .i_item       (w_head),
        .o_take       (w_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_text_valid (o_text_valid)
    );

endmodule

// ===== sv/cutv_checker.sv =====
// Port-level checks for canonical_utf8_text_validator_core, bound to it.
// Depends on canonical_utf8_text_validator_core_assert.svh.
`include "canonical_utf8_text_validator_core_assert.svh"

module cutv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_text_valid
);

    // No verdict may be waiting right after reset.
    `CUTV_ASSERT_CLK(a_empty_after_rst, i_clk, i_rst_n, !$past(i_rst_n) |-> empty, "verdict present after reset")

    // Input side must be open right after reset.
    `CUTV_ASSERT_ALWAYS(a_open_after_rst, i_clk, !i_rst_n |=> !full, "full asserted after reset")

    // A waiting verdict holds its value until popped.
    `CUTV_ASSERT_CLK(a_hold_verdict, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_text_valid)), "verdict changed while stalled")

    // The input side only fills up on a pushed item.
    `CUTV_ASSERT_CLK(a_full_after_push, i_clk, i_rst_n, $rose(full) |-> $past(push), "full rose without a pushed item")

endmodule

bind canonical_utf8_text_validator_core cutv_checker u_cutv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_text_valid (o_text_valid)
);
